FILE: src/fcull_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants of the frustum culling tester.
// ----------------------------------------------------------------------------
package fcull_pkg;

   localparam int PROD_W = 64;   // 32 x 32 signed product
   localparam int ACC_W  = 66;   // plane distance and extent term
   localparam int CMP_W  = 67;   // distance plus or minus extent

   localparam int PLANE_SLOTS = 7;   // plane slots held by the store

   localparam logic [1:0] OP_LOAD       = 2'd0;
   localparam logic [1:0] OP_BOX        = 2'd1;
   localparam logic [1:0] OP_BOX_NO_FAR = 2'd2;
   localparam logic [1:0] OP_SPHERE     = 2'd3;

   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

   localparam int          FAR_SLOT      = 5;
   localparam int          SPHERE_PLANES = 6;
   localparam logic [7:0]  MASK_DISABLED = 8'hFF;
   localparam logic [2:0]  COUNT_RESET   = 3'd6;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] offset;
      logic        [7:0]  mask;
   } plane_type;

   typedef struct packed {
      logic               is_sphere;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic        [30:0] hx;
      logic        [30:0] hy;
      logic        [30:0] hz;
   } item_type;

endpackage

FILE: src/fcull_plane_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_plane_store
// Register file of clip planes, one write port, every slot read in parallel.
// ----------------------------------------------------------------------------
module fcull_plane_store import fcull_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  logic [2:0] wr_index,
   input  plane_type wr_plane,
   output plane_type planes [PLANE_SLOTS]
);

   plane_type store_ff [PLANE_SLOTS];

   for (genvar i = 0; i < PLANE_SLOTS; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            store_ff[i] <= '{nx: '0, ny: '0, nz: '0, offset: '0, mask: MASK_DISABLED};
         end else if (wr_en && (32'(wr_index) == 32'(i))) begin
            store_ff[i] <= wr_plane;
         end
      end
      assign planes[i] = store_ff[i];
   end

endmodule

FILE: src/fcull_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_lane
// One plane: products, then distance and extent sums, then both compares.
// ----------------------------------------------------------------------------
module fcull_lane import fcull_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  logic      lane_en,
   input  item_type  item,
   input  plane_type plane,
   output logic      outside_flag,
   output logic      touch_flag
);

   // stage 2: products
   logic signed [PROD_W-1:0] pvx_ff, pvy_ff, pvz_ff, qx_ff, qy_ff, qz_ff;
   logic signed [31:0]       off2_ff;
   logic        [30:0]       rad2_ff;
   logic        [2:0]        sgn2_ff;
   logic                     sph2_ff, en2_ff;
   // stage 3: sums
   logic signed [ACC_W-1:0]  dist_ff, ext_ff;
   logic                     en3_ff;
   // stage 4: flags
   logic                     out4_ff, touch4_ff;

   logic signed [ACC_W-1:0]  dist_in, ext_in, tx, ty, tz;
   logic signed [CMP_W-1:0]  near_d, far_d;

   always_ff @(posedge clock) begin
      if (advance) begin
         pvx_ff  <= plane.nx * item.vx;
         pvy_ff  <= plane.ny * item.vy;
         pvz_ff  <= plane.nz * item.vz;
         qx_ff   <= plane.nx * $signed({1'b0, item.hx});
         qy_ff   <= plane.ny * $signed({1'b0, item.hy});
         qz_ff   <= plane.nz * $signed({1'b0, item.hz});
         off2_ff <= plane.offset;
         rad2_ff <= item.hx;
         sgn2_ff <= plane.mask[2:0];
         sph2_ff <= item.is_sphere;
         en2_ff  <= lane_en;
      end
   end

   always_comb begin
      tx = {{(ACC_W-PROD_W){qx_ff[PROD_W-1]}}, qx_ff};
      ty = {{(ACC_W-PROD_W){qy_ff[PROD_W-1]}}, qy_ff};
      tz = {{(ACC_W-PROD_W){qz_ff[PROD_W-1]}}, qz_ff};
      dist_in = {{(ACC_W-PROD_W){pvx_ff[PROD_W-1]}}, pvx_ff}
              + {{(ACC_W-PROD_W){pvy_ff[PROD_W-1]}}, pvy_ff}
              + {{(ACC_W-PROD_W){pvz_ff[PROD_W-1]}}, pvz_ff}
              + {{(ACC_W-48){off2_ff[31]}}, off2_ff, 16'b0};
      if (sph2_ff) begin
         ext_in = {{(ACC_W-47){1'b0}}, rad2_ff, 16'b0};
      end else begin
         ext_in = (sgn2_ff[0] ? tx : -tx) + (sgn2_ff[1] ? ty : -ty)
                + (sgn2_ff[2] ? tz : -tz);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_in;
         ext_ff  <= ext_in;
         en3_ff  <= en2_ff;
      end
   end

   // near corner: distance minus extent; far corner: distance plus extent
   assign near_d = {dist_ff[ACC_W-1], dist_ff} - {ext_ff[ACC_W-1], ext_ff};
   assign far_d  = {dist_ff[ACC_W-1], dist_ff} + {ext_ff[ACC_W-1], ext_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         out4_ff   <= en3_ff && !near_d[CMP_W-1] && (near_d != '0);
         touch4_ff <= en3_ff && !far_d[CMP_W-1] && (far_d != '0);
      end
   end

   assign outside_flag = out4_ff;
   assign touch_flag   = touch4_ff;

endmodule

FILE: src/frustum_cull_tester.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_tester
// Classifies boxes and spheres against up to seven stored clip planes.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one item per transfer: a plane load (no result), a box
//    test, a box test that skips the far plane, or a sphere test.
//  - rsp_* returns one verdict per test: 0 outside, 1 intersecting,
//    2 fully inside. Loads never produce a transfer on rsp_*.
//  - csr_* writes active_plane_count; csr_ready is always high. Write it
//    only while no test is in flight.
//  - A test's verdict passes stage 1, the lane stages and the output register
//    on its way to rsp_*. Throughput: one item per cycle unless rsp_stall holds the pipe; all planes are evaluated in
//    parallel lanes, each a three-stage multiply / sum / compare pipe.
//  - A load takes effect for every item that follows it and none before.
//  - Reset: all planes disabled (mask 255, zero normals), count 6, pipe empty.
//  - rsp_stall freezes the whole pipe once the output register is full;
//    req_stall then rises in the same cycle. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module frustum_cull_tester import fcull_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [2:0]         req_plane_index,
   input  logic [7:0]         req_plane_octant_mask,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_plane_offset,
   input  logic [30:0]        req_half_extent_x,
   input  logic [30:0]        req_half_extent_y,
   input  logic [30:0]        req_half_extent_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_verdict,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_active_plane_count
);

   logic advance;                 // whole pipe moves together
   logic [2:0] count_ff;

   // stage 1: registered request
   logic       s1_valid_ff;
   logic [1:0] s1_op_ff;
   logic [2:0] s1_index_ff;
   logic [7:0] s1_mask_ff;
   logic signed [31:0] s1_vx_ff, s1_vy_ff, s1_vz_ff, s1_off_ff;
   logic [30:0] s1_hx_ff, s1_hy_ff, s1_hz_ff;

   logic s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_verdict_ff, verdict_in;

   plane_type planes [PLANE_SLOTS];
   plane_type wr_plane;
   item_type  s1_item;
   logic      store_wr;
   logic [PLANE_SLOTS-1:0] lane_en, out_flags, touch_flags;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_active_plane_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= req_op;
         s1_index_ff <= req_plane_index;
         s1_mask_ff  <= req_plane_octant_mask;
         s1_vx_ff    <= req_vec_x;
         s1_vy_ff    <= req_vec_y;
         s1_vz_ff    <= req_vec_z;
         s1_off_ff   <= req_plane_offset;
         s1_hx_ff    <= req_half_extent_x;
         s1_hy_ff    <= req_half_extent_y;
         s1_hz_ff    <= req_half_extent_z;
      end
   end

   // Loads write the planes as they leave stage 1, the same place tests
   // read them, so item order is kept.
   assign store_wr = advance && s1_valid_ff && (s1_op_ff == OP_LOAD);
   assign wr_plane = '{nx: s1_vx_ff, ny: s1_vy_ff, nz: s1_vz_ff,
                       offset: s1_off_ff, mask: s1_mask_ff};

   fcull_plane_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (store_wr),
      .wr_index (s1_index_ff),
      .wr_plane (wr_plane),
      .planes   (planes)
   );

   assign s1_item = '{is_sphere: (s1_op_ff == OP_SPHERE), vx: s1_vx_ff, vy: s1_vy_ff,
                      vz: s1_vz_ff, hx: s1_hx_ff, hy: s1_hy_ff, hz: s1_hz_ff};

   for (genvar i = 0; i < PLANE_SLOTS; i++) begin : g_lane
      // box: walked slots with a valid octant, no far slot for OP_BOX_NO_FAR; sphere: first six not disabled
      always_comb begin
         if (s1_op_ff == OP_SPHERE) begin
            lane_en[i] = (i < SPHERE_PLANES) && (planes[i].mask != MASK_DISABLED);
         end else begin
            lane_en[i] = (32'(i) < 32'(count_ff)) && (planes[i].mask[7:3] == 5'd0)
                       && !((s1_op_ff == OP_BOX_NO_FAR) && (i == FAR_SLOT));
         end
      end

      fcull_lane u_lane (
         .clock        (clock),
         .advance      (advance),
         .lane_en      (lane_en[i]),
         .item         (s1_item),
         .plane        (planes[i]),
         .outside_flag (out_flags[i]),
         .touch_flag   (touch_flags[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid_ff && (s1_op_ff != OP_LOAD);
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // any outside plane wins over any intersect
   always_comb begin
      if (|out_flags) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (|touch_flags) begin
         verdict_in = VERDICT_INTERSECT;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef ASSERT_OFF
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      store_wr |=> !s2_valid_ff)
      else $error("plane load entered the test pipe");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s2_valid_ff) && $stable(s3_valid_ff) && $stable(s4_valid_ff)))
      else $error("pipe moved during a stall");

   a_test_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (advance && s4_valid_ff) |=> rsp_valid)
      else $error("test lost before the output register");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_OUTSIDE || rsp_verdict == VERDICT_INTERSECT
                     || rsp_verdict == VERDICT_INSIDE))
      else $error("bad verdict code");
`endif

endmodule
